@@ src/gbn_pkg.sv @@
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants of the Go-Back-N sender
// Sequence space, field widths, command and result codes, and the structs
// that pass between the front end and the back end.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // Sequence space is a power of two; indices wrap on SEQ_W bits.
  localparam int SEQ_SPACE    = 8;
  localparam int SEQ_W        = $clog2(SEQ_SPACE);
  localparam int PAYLOAD_BITS = 64;
  localparam int MAX_RESULTS  = 7;
  localparam int NCNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int CMD_W        = 2;
  localparam int ACK_W        = 4;
  localparam int KIND_W       = 3;
  localparam int TMR_W        = 2;
  localparam int WSIZE_W      = 3;

  // Queue depth is a power of two; pointers wrap on QPTR_W bits.
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 3'd4;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EMIT    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACKED   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DROPPED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_IDLE    = 3'd4;

  // Timer actions
  localparam logic [TMR_W-1:0] TMR_NONE    = 2'd0;
  localparam logic [TMR_W-1:0] TMR_START   = 2'd1;
  localparam logic [TMR_W-1:0] TMR_STOP    = 2'd2;
  localparam logic [TMR_W-1:0] TMR_RESTART = 2'd3;

  // Register index of window_size
  localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;

  // Decoded operation from front end to back end
  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [SEQ_W-1:0]        ack_base;
    logic                    ack_ok;
  } op_t;

  // One result transaction
  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [SEQ_W-1:0]        seq;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [TMR_W-1:0]        timer;
    logic                    last;
  } res_t;

endpackage

@@ src/gbn_front.sv @@
// ----------------------------------------------------------------------------
// gbn_front: command intake
// Accepts input transactions, drops unknown commands, precomputes the new
// window base of an ack and queues the decoded operation for the back end.
// ----------------------------------------------------------------------------
module gbn_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [gbn_pkg::CMD_W-1:0]          command,
  input  logic [gbn_pkg::PAYLOAD_BITS-1:0]   payload,
  input  logic signed [gbn_pkg::ACK_W-1:0]   ack_num,
  input  logic                               ack_checksum_ok,
  output logic                               op_valid,
  output gbn_pkg::op_t                       op,
  input  logic                               op_pop
);

  gbn_pkg::op_t                    q [gbn_pkg::QDEPTH];
  logic [gbn_pkg::QPTR_W-1:0]      wr_ptr;
  logic [gbn_pkg::QPTR_W-1:0]      rd_ptr;
  logic [gbn_pkg::QCNT_W-1:0]      count;
  logic                            accept;
  logic                            known;
  logic                            wr_en;
  logic                            rd_en;
  gbn_pkg::op_t                    dec;

  assign full     = (count == gbn_pkg::QCNT_W'(gbn_pkg::QDEPTH));
  assign op_valid = (count != '0);
  assign op       = q[rd_ptr];
  assign accept   = push && !full;
  assign known    = (command == gbn_pkg::CMD_SEND) || (command == gbn_pkg::CMD_ACK) ||
                    (command == gbn_pkg::CMD_TIMEOUT);
  assign wr_en    = accept && known;
  assign rd_en    = op_valid && op_pop;

  // (ack + 1) mod SEQ_SPACE: low bits of the two's complement sum
  always_comb begin
    dec.cmd      = command;
    dec.payload  = payload;
    dec.ack_base = gbn_pkg::SEQ_W'(ack_num[gbn_pkg::SEQ_W-1:0] + 1'b1);
    dec.ack_ok   = ack_checksum_ok;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/gbn_back.sv @@
// ----------------------------------------------------------------------------
// gbn_back: window engine
// Holds the window and the packet buffer, carries out send, ack and timeout
// operations and queues at most one result transaction per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module gbn_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [gbn_pkg::WSIZE_W-1:0]       window_size,
  input  logic                              op_valid,
  input  gbn_pkg::op_t                      op,
  output logic                              op_pop,
  output logic                              empty,
  input  logic                              pop,
  output gbn_pkg::res_t                     res
);

  logic [gbn_pkg::PAYLOAD_BITS-1:0] pbuf [gbn_pkg::SEQ_SPACE];

  logic [gbn_pkg::SEQ_W-1:0] window_base, window_base_next;
  logic [gbn_pkg::SEQ_W-1:0] next_sequence, next_sequence_next;
  logic                      walking, walking_next;
  logic [gbn_pkg::SEQ_W-1:0] walk_idx, walk_idx_next;
  logic [gbn_pkg::NCNT_W-1:0] walk_left, walk_left_next;

  gbn_pkg::res_t             rq [gbn_pkg::QDEPTH];
  logic [gbn_pkg::QPTR_W-1:0] wr_ptr;
  logic [gbn_pkg::QPTR_W-1:0] rd_ptr;
  logic [gbn_pkg::QCNT_W-1:0] count;

  logic                      room;
  logic                      emit;
  logic                      rd_en;
  gbn_pkg::res_t             res_new;
  logic                      buf_we;
  logic [gbn_pkg::SEQ_W-1:0] rd_idx_next;
  logic [gbn_pkg::PAYLOAD_BITS-1:0] rd_data;
  logic [gbn_pkg::SEQ_W-1:0] outstanding;
  logic [gbn_pkg::NCNT_W-1:0] n_tx;

  assign empty       = (count == '0);
  assign res         = rq[rd_ptr];
  assign rd_en       = pop && !empty;
  assign room        = (count != gbn_pkg::QCNT_W'(gbn_pkg::QDEPTH));
  assign outstanding = gbn_pkg::SEQ_W'(next_sequence - window_base);
  assign rd_idx_next = walking_next ? walk_idx_next : window_base_next;

  // Cap the retransmission burst
  always_comb begin
    if (gbn_pkg::NCNT_W'(outstanding) > gbn_pkg::NCNT_W'(gbn_pkg::MAX_RESULTS)) begin
      n_tx = gbn_pkg::NCNT_W'(gbn_pkg::MAX_RESULTS);
    end else begin
      n_tx = gbn_pkg::NCNT_W'(outstanding);
    end
  end

  always_comb begin
    window_base_next   = window_base;
    next_sequence_next = next_sequence;
    walking_next       = walking;
    walk_idx_next      = walk_idx;
    walk_left_next     = walk_left;
    op_pop             = 1'b0;
    emit               = 1'b0;
    buf_we             = 1'b0;
    res_new            = '0;
    res_new.last       = 1'b1;
    if (room) begin
      if (walking) begin
        // Continue the retransmission burst
        emit            = 1'b1;
        res_new.kind    = gbn_pkg::KIND_EMIT;
        res_new.seq     = walk_idx;
        res_new.payload = rd_data;
        res_new.timer   = gbn_pkg::TMR_NONE;
        res_new.last    = (walk_left == gbn_pkg::NCNT_W'(1));
        walk_idx_next   = walk_idx + 1'b1;
        walk_left_next  = walk_left - 1'b1;
        walking_next    = (walk_left != gbn_pkg::NCNT_W'(1));
      end else if (op_valid) begin
        op_pop = 1'b1;
        emit   = 1'b1;
        case (op.cmd)
          gbn_pkg::CMD_SEND: begin
            if (outstanding >= window_size) begin
              res_new.kind = gbn_pkg::KIND_REFUSED;
            end else begin
              buf_we             = 1'b1;
              res_new.kind       = gbn_pkg::KIND_EMIT;
              res_new.seq        = next_sequence;
              res_new.payload    = op.payload;
              res_new.timer      = (outstanding == '0) ? gbn_pkg::TMR_START
                                                       : gbn_pkg::TMR_NONE;
              next_sequence_next = next_sequence + 1'b1;
            end
          end
          gbn_pkg::CMD_ACK: begin
            if (!op.ack_ok) begin
              res_new.kind = gbn_pkg::KIND_DROPPED;
            end else begin
              window_base_next = op.ack_base;
              res_new.kind     = gbn_pkg::KIND_ACKED;
              res_new.timer    = (op.ack_base == next_sequence) ? gbn_pkg::TMR_STOP
                                                                : gbn_pkg::TMR_RESTART;
            end
          end
          gbn_pkg::CMD_TIMEOUT: begin
            if (outstanding == '0) begin
              res_new.kind = gbn_pkg::KIND_IDLE;
            end else begin
              // First packet now, the rest in the walking state that follows
              res_new.kind    = gbn_pkg::KIND_EMIT;
              res_new.seq     = window_base;
              res_new.payload = rd_data;
              res_new.timer   = gbn_pkg::TMR_START;
              res_new.last    = (n_tx == gbn_pkg::NCNT_W'(1));
              walking_next    = (n_tx != gbn_pkg::NCNT_W'(1));
              walk_idx_next   = window_base + 1'b1;
              walk_left_next  = n_tx - 1'b1;
            end
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
    end
  end

  // Prefetch the entry the engine reads next cycle; forward a write to it
  always_ff @(posedge clk) begin
    if (buf_we) begin
      pbuf[next_sequence] <= op.payload;
    end
    if (buf_we && (next_sequence == rd_idx_next)) begin
      rd_data <= op.payload;
    end else begin
      rd_data <= pbuf[rd_idx_next];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rq[wr_ptr] <= res_new;
    end
    walk_idx  <= walk_idx_next;
    walk_left <= walk_left_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base   <= '0;
      next_sequence <= '0;
      walking       <= 1'b0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      window_base   <= window_base_next;
      next_sequence <= next_sequence_next;
      walking       <= walking_next;
      if (emit) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (emit && !rd_en) begin
        count <= count + 1'b1;
      end else if (!emit && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/go_back_n_sender_top.sv @@
// ----------------------------------------------------------------------------
// go_back_n_sender_top: Go-Back-N sliding-window sender
// Send, ack and timeout commands go in through a queue-style port; emitted
// packets and status results come out through another. window_size is set
// over an APB-style register port.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | fields
//  ---------+------------------------+------------------------------------------------------
//  command  | push, full             | command, payload, ack_num, ack_checksum_ok
//  result   | empty, pop             | result_kind, out_seq, out_payload, timer_action, last
//  register | psel, penable, pwrite  | window_size at address 0 (pwdata in, prdata out)
//
//  An accepted command transaction is registered in the command queue before the engine
//  takes it. Send and ack each give one result; a timeout with n packets outstanding
//  retransmits n packets (at most seven), one buffered packet a cycle while the result
//  queue has room. Two-entry queues on each side let the engine stall only on a full
//  result queue and the input only on a full command queue. Synchronous reset empties
//  both queues, clears the window and sets window_size to 4.
// ----------------------------------------------------------------------------
module go_back_n_sender_top (
  input  logic                                  clk,
  input  logic                                  rst,
  // command transactions
  input  logic                                  push,
  output logic                                  full,
  input  logic [gbn_pkg::CMD_W-1:0]             command,
  input  logic [gbn_pkg::PAYLOAD_BITS-1:0]      payload,
  input  logic signed [gbn_pkg::ACK_W-1:0]      ack_num,
  input  logic                                  ack_checksum_ok,
  // result transactions
  output logic                                  empty,
  input  logic                                  pop,
  output logic [gbn_pkg::KIND_W-1:0]            result_kind,
  output logic [gbn_pkg::SEQ_W-1:0]             out_seq,
  output logic [gbn_pkg::PAYLOAD_BITS-1:0]      out_payload,
  output logic [gbn_pkg::TMR_W-1:0]             timer_action,
  output logic                                  last,
  // register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [gbn_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [gbn_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready
);

  logic [gbn_pkg::WSIZE_W-1:0] window_size;
  logic                        cfg_wr;
  logic                        sel_wsize;
  logic                        op_valid;
  logic                        op_pop;
  gbn_pkg::op_t                op;
  gbn_pkg::res_t               res;

  // Register port: zero wait states; register index is the word address
  assign pready    = 1'b1;
  assign sel_wsize = (paddr[gbn_pkg::CFG_ADDR_W-1] == gbn_pkg::REG_WINDOW_SIZE) &&
                     (paddr[1:0] == 2'b00);
  assign cfg_wr    = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= gbn_pkg::WSIZE_RESET;
    end else if (cfg_wr && sel_wsize) begin
      window_size <= pwdata[gbn_pkg::WSIZE_W-1:0];
    end
  end

  // Return window_size at its address, zero elsewhere
  always_comb begin
    prdata = '0;
    if (sel_wsize) begin
      prdata = gbn_pkg::CFG_DATA_W'(window_size);
    end
  end

  // Front end: accept and decode command transactions, drop unknown ones
  gbn_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .command         (command),
    .payload         (payload),
    .ack_num         (ack_num),
    .ack_checksum_ok (ack_checksum_ok),
    .op_valid        (op_valid),
    .op              (op),
    .op_pop          (op_pop)
  );

  // Back end: window state, packet buffer and result queue
  gbn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .window_size (window_size),
    .op_valid    (op_valid),
    .op          (op),
    .op_pop      (op_pop),
    .empty       (empty),
    .pop         (pop),
    .res         (res)
  );

  assign result_kind  = res.kind;
  assign out_seq      = res.seq;
  assign out_payload  = res.payload;
  assign timer_action = res.timer;
  assign last         = res.last;

endmodule
